### rtl/odd_even_transposition_sorter_defines.svh
// Assertion macros for the odd-even transposition sorter.
`ifndef ODD_EVEN_TRANSPOSITION_SORTER_DEFINES_SVH
`define ODD_EVEN_TRANSPOSITION_SORTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define OETS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define OETS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OETS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define OETS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/oets_pkg.sv
// Shared types and constants of the odd-even transposition sorter.
package oets_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SORT,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     odd_phase;
    } cell_ctrl_t;

endpackage

### rtl/oets_in_if.sv
// Input channel: one list element per transaction.
interface oets_in_if;
    logic                valid;
    logic                ready;
    oets_pkg::data_t     value;
    logic                final_item;

    modport source (output valid, output value, output final_item, input ready);
    modport sink   (input valid, input value, input final_item, output ready);
endinterface

### rtl/oets_out_if.sv
// Output channel: one sorted element per transaction.
interface oets_out_if;
    logic                valid;
    logic                ready;
    oets_pkg::data_t     sorted_value;
    logic                end_of_list;
    logic                overflowed;

    modport source (output valid, output sorted_value, output end_of_list,
                    output overflowed, input ready);
    modport sink   (input valid, input sorted_value, input end_of_list,
                    input overflowed, output ready);
endinterface

### rtl/odd_even_transposition_sorter.sv
// Top level of the odd-even transposition sorter: control and the cell chain.
//
// Channel   Modport  Payload                                   Moves
// items     sink     value, final_item                         one element
// results   source   sorted_value, end_of_list, overflowed     one sorted element
//
// Elements are loaded only in the load state; items is ready only while loading.
// After the final element the chain runs N compare-exchange phases (N = stored count).
// Results leave from cell 0 at one per cycle while results.ready is high; the
// chain shifts towards cell 0 on each transaction.
// Reset clears control state only; no clearing pass is needed.
// A stall on results holds the chain; no new list is taken until the last result goes.
`include "odd_even_transposition_sorter_defines.svh"

module odd_even_transposition_sorter #(
    parameter int MAX_ITEMS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    oets_in_if.sink     items,
    oets_out_if.source  results
);

    localparam int CW = $clog2(MAX_ITEMS + 1);

    oets_pkg::state_t     state_reg;
    oets_pkg::state_t     state_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [CW-1:0]        phase_reg;
    logic [CW-1:0]        phase_next;
    logic                 dropped_reg;
    logic                 dropped_next;
    logic                 in_fire;
    logic                 out_fire;
    logic                 full;
    logic                 last_phase;
    oets_pkg::cell_ctrl_t ctrl;
    oets_pkg::data_t      cell_value [MAX_ITEMS];

    assign in_fire    = items.valid && items.ready;
    assign out_fire   = results.valid && results.ready;
    assign full       = (count_reg == CW'(MAX_ITEMS));
    assign last_phase = (phase_reg == (count_reg - CW'(1)));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            oets_pkg::ST_LOAD:
            begin
                if (in_fire && items.final_item)
                begin
                    state_next = oets_pkg::ST_SORT;
                end
            end
            oets_pkg::ST_SORT:
            begin
                if (last_phase)
                begin
                    state_next = oets_pkg::ST_EMIT;
                end
            end
            oets_pkg::ST_EMIT:
            begin
                if (out_fire && results.end_of_list)
                begin
                    state_next = oets_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = oets_pkg::ST_LOAD;
            end
        endcase
    end

    // outputs and cell commands
    always_comb
    begin
        items.ready    = 1'b0;
        results.valid  = 1'b0;
        ctrl.op        = oets_pkg::CELL_HOLD;
        ctrl.odd_phase = phase_reg[0];
        case (state_reg)
            oets_pkg::ST_LOAD:
            begin
                items.ready = 1'b1;
                if (items.valid && !full)
                begin
                    ctrl.op = oets_pkg::CELL_LOAD;
                end
            end
            oets_pkg::ST_SORT:
            begin
                ctrl.op = oets_pkg::CELL_SORT;
            end
            oets_pkg::ST_EMIT:
            begin
                results.valid = 1'b1;
                if (results.ready)
                begin
                    ctrl.op = oets_pkg::CELL_SHIFT;
                end
            end
            default:
            begin
                ctrl.op = oets_pkg::CELL_HOLD;
            end
        endcase
    end

    assign results.sorted_value = cell_value[0];
    assign results.end_of_list  = (count_reg == CW'(1));
    assign results.overflowed   = dropped_reg;

    // counters and the overflow mark
    always_comb
    begin
        count_next   = count_reg;
        phase_next   = phase_reg;
        dropped_next = dropped_reg;
        if (in_fire)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        if (state_reg == oets_pkg::ST_SORT)
        begin
            phase_next = last_phase ? '0 : (phase_reg + CW'(1));
        end
        if (out_fire)
        begin
            count_next = count_reg - CW'(1);
            if (results.end_of_list)
            begin
                dropped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= oets_pkg::ST_LOAD;
            count_reg   <= '0;
            phase_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            phase_reg   <= phase_next;
            dropped_reg <= dropped_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < MAX_ITEMS; i++)
        begin : g_cell
            oets_pkg::data_t left_value;
            oets_pkg::data_t right_value;
            if (i == 0)
            begin : g_first
                assign left_value = cell_value[i];
            end
            else
            begin : g_inner_left
                assign left_value = cell_value[i-1];
            end
            if (i == MAX_ITEMS - 1)
            begin : g_last
                assign right_value = cell_value[i];
            end
            else
            begin : g_inner_right
                assign right_value = cell_value[i+1];
            end
            oets_cell #(
                .IDX (i),
                .CW  (CW)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .count      (count_reg),
                .load_value (items.value),
                .left       (left_value),
                .right      (right_value),
                .value      (cell_value[i])
            );
        end
    endgenerate

    `OETS_ASSERT_NOW(a_emit_nonempty, clk, rst_n, results.valid, count_reg != '0, "result offered from an empty chain")
    `OETS_ASSERT_NEXT(a_final_starts_sort, clk, rst_n, in_fire && items.final_item, (state_reg == oets_pkg::ST_SORT) && (phase_reg == '0), "final element did not start the sort")
    `OETS_ASSERT_NEXT(a_list_closed, clk, rst_n, out_fire && results.end_of_list, (state_reg == oets_pkg::ST_LOAD) && (count_reg == '0) && !dropped_reg, "list not cleared after last result")
    `OETS_ASSERT_NOW(a_phase_bound, clk, rst_n, state_reg == oets_pkg::ST_SORT, phase_reg < count_reg, "phase ran past the stored count")

endmodule

### rtl/oets_cell.sv
// One storage cell of the transposition chain with its compare-exchange.
module oets_cell #(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  logic                clk,
    input  oets_pkg::cell_ctrl_t ctrl,
    input  logic [CW-1:0]       count,
    input  oets_pkg::data_t     load_value,
    input  oets_pkg::data_t     left,
    input  oets_pkg::data_t     right,
    output oets_pkg::data_t     value
);

    localparam logic IDX_ODD  = (IDX % 2) != 0;
    localparam logic HAS_LEFT = IDX > 0;

    oets_pkg::data_t value_reg;
    oets_pkg::data_t value_next;
    logic            low_side;
    logic            low_pair;
    logic            high_pair;

    always_comb
    begin
        low_side   = (ctrl.odd_phase == IDX_ODD);
        low_pair   = low_side && (CW'(IDX + 1) < count);
        high_pair  = !low_side && HAS_LEFT && (CW'(IDX) < count);
        value_next = value_reg;
        case (ctrl.op)
            oets_pkg::CELL_LOAD:
            begin
                if (count == CW'(IDX))
                begin
                    value_next = load_value;
                end
            end
            oets_pkg::CELL_SORT:
            begin
                // low end of a pair keeps the minimum, high end the maximum
                if (low_pair && (value_reg > right))
                begin
                    value_next = right;
                end
                else if (high_pair && (left > value_reg))
                begin
                    value_next = left;
                end
            end
            oets_pkg::CELL_SHIFT:
            begin
                value_next = right;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

### tb/sv/odd_even_transposition_sorter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the odd-even transposition sorter, with random lists.
module odd_even_transposition_sorter_tb;

    localparam int              CAPACITY    = 32;
    localparam int              HALF_CYCLE  = 4;
    localparam int              ITEM_GOAL   = 480;
    localparam int              CYCLE_LIMIT = 400000;
    localparam oets_pkg::data_t MOST_NEG    = 32'sh8000_0000;
    localparam oets_pkg::data_t MOST_POS    = 32'sh7FFF_FFFF;

    typedef struct {
        oets_pkg::data_t value;
        logic            last;
        logic            ovf;
    } sorted_entry_t;

    class sorted_list_board;
        oets_pkg::data_t gathered[$];
        logic            dropped = 1'b0;
        sorted_entry_t   awaited[$];
        int              errors  = 0;

        // Store or drop the element; on the final one sort the list and queue its results.
        function void note_item(oets_pkg::data_t v, logic fin);
            oets_pkg::data_t work[CAPACITY];
            oets_pkg::data_t held;
            sorted_entry_t   entry;
            int              n;
            int              ph;
            int              k;
            if (gathered.size() < CAPACITY)
                gathered.push_back(v);
            else
                dropped = 1'b1;
            if (!fin)
                return;
            n = gathered.size();
            for (k = 0; k < n; k++)
                work[k] = gathered[k];
            // even phases pair (0,1),(2,3)..., odd phases pair (1,2),(3,4)...
            for (ph = 0; ph < n; ph++)
            begin
                for (k = ph % 2; k + 1 < n; k += 2)
                begin
                    if (work[k] > work[k+1])
                    begin
                        held      = work[k];
                        work[k]   = work[k+1];
                        work[k+1] = held;
                    end
                end
            end
            for (k = 0; k < n; k++)
            begin
                entry.value = work[k];
                entry.last  = (k == n - 1);
                entry.ovf   = dropped;
                awaited.push_back(entry);
            end
            gathered.delete();
            dropped = 1'b0;
        endfunction

        function void check_result(oets_pkg::data_t v, logic eol, logic ovf);
            sorted_entry_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result value %0d end_of_list %b overflowed %b",
                         $time, v, eol, ovf);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (v !== want.value || eol !== want.last || ovf !== want.ovf)
            begin
                $display("%0t: mismatch expected value %0d end_of_list %b overflowed %b",
                         $time, want.value, want.last, want.ovf);
                $display("%0t:          actual   value %0d end_of_list %b overflowed %b",
                         $time, v, eol, ovf);
                errors++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    int               cycles = 0;
    int               items_sent = 0;
    bit               tx_calm = 1'b0;
    bit               rx_calm = 1'b0;
    sorted_list_board board = new();

    oets_in_if  items();
    oets_out_if results();

    odd_even_transposition_sorter #(.MAX_ITEMS(CAPACITY)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results)
    );

    always #(HALF_CYCLE) clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int gap_length(bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic oets_pkg::data_t draw_value(int mode);
        case (mode)
            0: return oets_pkg::data_t'($urandom);
            1: return oets_pkg::data_t'(int'($urandom_range(0, 8)) - 4);
            default:
                case ($urandom_range(0, 4))
                    0: return MOST_NEG;
                    1: return MOST_POS;
                    2: return '0;
                    3: return '1;
                    default: return oets_pkg::data_t'($urandom);
                endcase
        endcase
    endfunction

    task automatic send_item(oets_pkg::data_t v, logic fin);
        int gap;
        gap = gap_length(tx_calm);
        if (gap > 0)
        begin
            items.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items.valid      <= 1'b1;
        items.value      <= v;
        items.final_item <= fin;
        do
            @(posedge clk);
        while (items.ready !== 1'b1);
        board.note_item(v, fin);
        items_sent++;
    endtask

    task automatic send_list(oets_pkg::data_t vals[$]);
        int k;
        for (k = 0; k < vals.size(); k++)
            send_item(vals[k], k == vals.size() - 1);
    endtask

    // Drop valid and hold the sender until every queued result has come back.
    task automatic hold_until_drained();
        items.valid <= 1'b0;
        @(posedge clk);
        while (board.awaited.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        oets_pkg::data_t vals[$];
        int              len;
        int              mode;
        int              roll;
        int              k;
        bit              first_random;
        items.valid      = 1'b0;
        items.value      = '0;
        items.final_item = 1'b0;
        rst_n            = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single elements at both extremes, extremes mixed, duplicates, sorted and reversed
        vals = '{MOST_POS};
        send_list(vals);
        vals = '{MOST_NEG};
        send_list(vals);
        vals = '{MOST_POS, MOST_NEG};
        send_list(vals);
        vals = '{32'sd0, -32'sd1, 32'sd1, MOST_NEG, MOST_POS};
        send_list(vals);
        vals = '{32'sd7, 32'sd7, -32'sd7, 32'sd7};
        send_list(vals);
        vals = '{-32'sd3, -32'sd2, -32'sd1, 32'sd0, 32'sd1, 32'sd2};
        send_list(vals);
        vals = '{32'sd5, 32'sd4, 32'sd3, 32'sd2, 32'sd1};
        send_list(vals);

        first_random = 1'b1;
        while (items_sent < ITEM_GOAL)
        begin
            if (first_random || $urandom_range(0, 5) == 0)
                hold_until_drained();
            first_random = 1'b0;
            tx_calm = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 12)
                len = $urandom_range(1, 3);
            else if (roll < 75)
                len = $urandom_range(4, CAPACITY - 1);
            else if (roll < 87)
                len = CAPACITY;
            else
                len = $urandom_range(CAPACITY + 1, CAPACITY + 8);
            mode = $urandom_range(0, 2);
            vals.delete();
            for (k = 0; k < len; k++)
                vals.push_back(draw_value(mode));
            send_list(vals);
        end

        hold_until_drained();
        repeat (40) @(posedge clk);
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Result side: check each transaction and stall at random.
    initial
    begin
        int stall_left;
        stall_left    = 0;
        results.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && results.valid === 1'b1 && results.ready === 1'b1)
                board.check_result(results.sorted_value, results.end_of_list,
                                   results.overflowed);
            if (cycles % 256 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            if (stall_left > 0)
            begin
                stall_left--;
                results.ready <= 1'b0;
            end
            else
            begin
                results.ready <= 1'b1;
                stall_left = gap_length(rx_calm);
            end
        end
    end

endmodule

### odd_even_transposition_sorter.f
+incdir+rtl
rtl/oets_pkg.sv
rtl/oets_in_if.sv
rtl/oets_out_if.sv
rtl/oets_cell.sv
rtl/odd_even_transposition_sorter.sv
tb/sv/odd_even_transposition_sorter_tb.sv
